### sv/fmmp_pkg.sv
// ----------------------------------------------------------------------------
// fmmp_pkg
// shared types and constants of the fibonacci matrix power unit
// ----------------------------------------------------------------------------
package fmmp_pkg;

  localparam int unsigned MOD_W = 31;   // modulus and residue width
  localparam int unsigned IN_W  = 32;   // exponent port width
  localparam int unsigned CNT_W = 5;    // counts MOD_W multiplier steps

  localparam logic [MOD_W-1:0] MODULUS_RESET = 31'd111539786;
  localparam logic [CNT_W-1:0] CNT_LAST      = CNT_W'(MOD_W - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BIT,
    ST_OPND,
    ST_MUL,
    ST_TERM,
    ST_COMMIT
  } state_t;

  // which matrix product is in flight
  typedef enum logic {
    OP_MUL,   // s = p * s
    OP_SQR    // p = p * p
  } op_t;

  function automatic logic [MOD_W-1:0] sel4(input logic [1:0] idx,
                                            input logic [MOD_W-1:0] v0,
                                            input logic [MOD_W-1:0] v1,
                                            input logic [MOD_W-1:0] v2,
                                            input logic [MOD_W-1:0] v3);
    logic [MOD_W-1:0] r;
    unique case (idx)
      2'd0:    r = v0;
      2'd1:    r = v1;
      2'd2:    r = v2;
      default: r = v3;
    endcase
    return r;
  endfunction

endpackage

### sv/fibonacci_mod_matrix_power_unit.sv
// ----------------------------------------------------------------------------
// fibonacci_mod_matrix_power_unit
// F(n+1) mod m as the lower-right entry of [[0,1],[1,1]]^n
// ----------------------------------------------------------------------------
// usage
//   input: pulse start with in_exponent while busy is low; the transfer
//   happens at that edge and busy rises on the next cycle
//   result: out_strobe is high for exactly one cycle with out_fib_value;
//   the receiver cannot stall, so the result is simply taken there
//   config: cfg_valid/cfg_ready write the 31-bit modulus; cfg_ready is
//   high while the unit is idle and start is low
// datapath
//   one bit-serial modular multiplier, with an operand load step before
//   and an accumulate step after each product, is shared by all products;
//   one 2x2 matrix product is 8 of them
//   with L = index of the highest set exponent bit plus one and k = its
//   popcount, an item takes L - 1 + k matrix products;
//   n = 0 needs none
//   one item at a time: busy stays high until the result strobe
// reset
//   rst_n is synchronous; it returns to idle, drops the strobe and loads
//   the modulus reset value
// ----------------------------------------------------------------------------
module fibonacci_mod_matrix_power_unit
  import fmmp_pkg::*;
#(
  parameter int unsigned EXP_BITS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  // input channel
  input  logic             start,
  output logic             busy,
  input  logic [IN_W-1:0]  in_exponent,
  // result channel
  output logic             out_strobe,
  output logic [MOD_W-1:0] out_fib_value,
  // configuration channel
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [MOD_W-1:0] cfg_data
);

  // control state
  state_t           state_r, state_nxt;
  op_t              op_r, op_nxt;
  logic [1:0]       ent_r, ent_nxt;      // matrix entry being built
  logic             term_r, term_nxt;    // which product of the dot
  logic [CNT_W-1:0] cnt_r, cnt_nxt;      // multiplier bit step
  logic             out_strobe_r, out_strobe_nxt;
  logic [MOD_W-1:0] modulus_r;

  // payload
  logic [EXP_BITS-1:0] exp_r, exp_nxt;
  logic [MOD_W-1:0]    p0_r, p1_r, p2_r, p3_r;
  logic [MOD_W-1:0]    s0_r, s1_r, s2_r, s3_r;
  logic [MOD_W-1:0]    t0_r, t1_r, t2_r, t3_r;
  logic [MOD_W-1:0]    mul_a_r, mul_b_r, acc_r, prod0_r;
  logic [MOD_W-1:0]    out_fib_value_r, out_fib_value_nxt;

  logic [MOD_W-1:0] one_mod;       // 1 % m for m >= 1
  logic [MOD_W-1:0] opnd_x, opnd_y;
  logic [MOD_W:0]   dbl, dbl_red, add, add_red;
  logic [MOD_W:0]   sum, sum_red;
  logic             accepted;

  assign busy          = (state_r != ST_IDLE);
  // a modulus write never shares an edge with an input transfer
  assign cfg_ready     = ~busy & ~start;
  assign out_strobe    = out_strobe_r;
  assign out_fib_value = out_fib_value_r;
  assign accepted      = start & ~busy;

  assign one_mod = (modulus_r == MOD_W'(1)) ? '0 : MOD_W'(1);

  // operand pick: x is always p, y is s for the multiply step, p for squaring
  // entry (r,c) = x[r,0]*y[0,c] + x[r,1]*y[1,c]
  always_comb begin
    opnd_x = sel4({ent_r[1], term_r}, p0_r, p1_r, p2_r, p3_r);
    if (op_r == OP_MUL) begin
      opnd_y = sel4({term_r, ent_r[0]}, s0_r, s1_r, s2_r, s3_r);
    end else begin
      opnd_y = sel4({term_r, ent_r[0]}, p0_r, p1_r, p2_r, p3_r);
    end
  end

  // shared multiplier step: acc = (2*acc + bit*a) mod m, msb of b first
  always_comb begin
    dbl     = {acc_r, 1'b0};
    dbl_red = (dbl >= {1'b0, modulus_r}) ? dbl - {1'b0, modulus_r} : dbl;
    add     = dbl_red + (mul_b_r[MOD_W-1] ? {1'b0, mul_a_r} : '0);
    add_red = (add >= {1'b0, modulus_r}) ? add - {1'b0, modulus_r} : add;
  end

  // modular sum of the two products of one entry
  always_comb begin
    sum     = {1'b0, prod0_r} + {1'b0, acc_r};
    sum_red = (sum >= {1'b0, modulus_r}) ? sum - {1'b0, modulus_r} : sum;
  end

  // sequencer
  always_comb begin
    state_nxt         = state_r;
    op_nxt            = op_r;
    ent_nxt           = ent_r;
    term_nxt          = term_r;
    cnt_nxt           = cnt_r;
    exp_nxt           = exp_r;
    out_strobe_nxt    = 1'b0;
    out_fib_value_nxt = out_fib_value_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accepted) begin
          exp_nxt   = EXP_BITS'(in_exponent);
          state_nxt = ST_BIT;
        end
      end
      ST_BIT: begin
        ent_nxt  = 2'd0;
        term_nxt = 1'b0;
        if (exp_r == '0) begin
          // no modulus means no reduction: result is zero
          out_strobe_nxt    = 1'b1;
          out_fib_value_nxt = (modulus_r == '0) ? '0 : s3_r;
          state_nxt         = ST_IDLE;
        end else begin
          op_nxt    = exp_r[0] ? OP_MUL : OP_SQR;
          state_nxt = ST_OPND;
        end
      end
      ST_OPND: begin
        cnt_nxt   = '0;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_LAST) begin
          state_nxt = ST_TERM;
        end
      end
      ST_TERM: begin
        if (!term_r) begin
          term_nxt  = 1'b1;
          state_nxt = ST_OPND;
        end else begin
          term_nxt = 1'b0;
          if (ent_r == 2'd3) begin
            state_nxt = ST_COMMIT;
          end else begin
            ent_nxt   = ent_r + 2'd1;
            state_nxt = ST_OPND;
          end
        end
      end
      ST_COMMIT: begin
        ent_nxt  = 2'd0;
        term_nxt = 1'b0;
        if (op_r == OP_MUL && (exp_r >> 1) != '0) begin
          op_nxt    = OP_SQR;
          state_nxt = ST_OPND;
        end else begin
          // squaring done, or last set bit: the final squaring is not needed
          exp_nxt   = exp_r >> 1;
          state_nxt = ST_BIT;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_strobe_r <= 1'b0;
      modulus_r    <= MODULUS_RESET;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_valid && cfg_ready) begin
        modulus_r <= cfg_data;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    op_r            <= op_nxt;
    ent_r           <= ent_nxt;
    term_r          <= term_nxt;
    cnt_r           <= cnt_nxt;
    exp_r           <= exp_nxt;
    out_fib_value_r <= out_fib_value_nxt;

    if (accepted) begin
      // p = Q, s = identity, both reduced
      p0_r <= '0;
      p1_r <= one_mod;
      p2_r <= one_mod;
      p3_r <= one_mod;
      s0_r <= one_mod;
      s1_r <= '0;
      s2_r <= '0;
      s3_r <= one_mod;
    end

    if (state_r == ST_OPND) begin
      mul_a_r <= opnd_x;
      mul_b_r <= opnd_y;
      acc_r   <= '0;
    end

    if (state_r == ST_MUL) begin
      acc_r   <= add_red[MOD_W-1:0];
      mul_b_r <= {mul_b_r[MOD_W-2:0], 1'b0};
    end

    if (state_r == ST_TERM) begin
      if (!term_r) begin
        prod0_r <= acc_r;
      end else begin
        unique case (ent_r)
          2'd0:    t0_r <= sum_red[MOD_W-1:0];
          2'd1:    t1_r <= sum_red[MOD_W-1:0];
          2'd2:    t2_r <= sum_red[MOD_W-1:0];
          default: t3_r <= sum_red[MOD_W-1:0];
        endcase
      end
    end

    if (state_r == ST_COMMIT) begin
      if (op_r == OP_MUL) begin
        s0_r <= t0_r;
        s1_r <= t1_r;
        s2_r <= t2_r;
        s3_r <= t3_r;
      end else begin
        p0_r <= t0_r;
        p1_r <= t1_r;
        p2_r <= t2_r;
        p3_r <= t3_r;
      end
    end
  end

endmodule

### tb/fibonacci_mod_matrix_power_unit_test.sv
// ----------------------------------------------------------------------------
// fibonacci_mod_matrix_power_unit_test
// self-checking bench for the fibonacci matrix power unit: a directed table
// of exponents and modulus settings, then random phases, each result scored
// against a typed-in value or a local square-and-multiply predictor
// ----------------------------------------------------------------------------
module fibonacci_mod_matrix_power_unit_test
  import fmmp_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD  = 20;
  localparam int RESET_TICKS = 4;
  // the watchdog limit lies well above the time a full 32-bit exponent
  // takes and above the longest sender gap
  localparam int STALL_LIMIT = 100000;
  // quiet cycles after the last result, to catch stray strobes
  localparam int TAIL_CYCLES = 400;
  localparam int NUM_PHASES  = 8;
  localparam int REPORT_MAX  = 10;

  localparam logic [MOD_W-1:0] MOD_MAX = {MOD_W{1'b1}};

  // one row of the directed table; fib is typed in only where known is set
  typedef struct packed {
    logic [MOD_W-1:0] modulus;
    logic [IN_W-1:0]  exponent;
    logic             known;
    logic [MOD_W-1:0] fib;
  } dir_row_t;

  // 2x2 matrix [a b; c d], wide enough for a product of two residues
  typedef struct packed {
    logic [63:0] a, b, c, d;
  } mat2_t;

  localparam dir_row_t DIR_TABLE [23] = '{
    // reset modulus: small exponents give plain fibonacci numbers
    '{MODULUS_RESET, 32'd0,          1'b1, 31'd1},
    '{MODULUS_RESET, 32'd1,          1'b1, 31'd1},
    '{MODULUS_RESET, 32'd2,          1'b1, 31'd2},
    '{MODULUS_RESET, 32'd3,          1'b1, 31'd3},
    '{MODULUS_RESET, 32'd10,         1'b1, 31'd89},
    // F(40) is the last value below the reset modulus
    '{MODULUS_RESET, 32'd39,         1'b1, 31'd102334155},
    '{MODULUS_RESET, 32'h8000_0000,  1'b0, 31'd0},
    '{MODULUS_RESET, 32'hFFFF_FFFF,  1'b0, 31'd0},
    '{MODULUS_RESET, 32'h5555_5555,  1'b0, 31'd0},
    // largest modulus; F(46) still fits below it
    '{MOD_MAX,       32'd0,          1'b1, 31'd1},
    '{MOD_MAX,       32'd45,         1'b1, 31'd1836311903},
    '{MOD_MAX,       32'hFFFF_FFFF,  1'b0, 31'd0},
    '{MOD_MAX,       32'hAAAA_AAAA,  1'b0, 31'd0},
    // smallest legal modulus
    '{31'd2,         32'd0,          1'b1, 31'd1},
    '{31'd2,         32'd2,          1'b1, 31'd0},
    '{31'd2,         32'd3,          1'b1, 31'd1},
    '{31'd2,         32'hFFFF_FFFF,  1'b0, 31'd0},
    // modulus zero: no reduction possible, result forced to zero
    '{31'd0,         32'd0,          1'b1, 31'd0},
    '{31'd0,         32'hFFFF_FFFF,  1'b1, 31'd0},
    // modulus one: every residue is zero
    '{31'd1,         32'd0,          1'b1, 31'd0},
    '{31'd1,         32'd12345,      1'b1, 31'd0},
    // F(8) = 21, F(9) = 34
    '{31'd3,         32'd7,          1'b1, 31'd0},
    '{31'd3,         32'd8,          1'b1, 31'd1}
  };

  logic             clk         = 1'b0;
  logic             rst_n       = 1'b0;
  logic             start       = 1'b0;
  logic             busy;
  logic [IN_W-1:0]  in_exponent = '0;
  logic             out_strobe;
  logic [MOD_W-1:0] out_fib_value;
  logic             cfg_valid   = 1'b0;
  logic             cfg_ready;
  logic [MOD_W-1:0] cfg_data    = '0;

  // residues still owed by the unit, oldest first
  logic [MOD_W-1:0] fib_expected_q [$];
  // modulus the unit holds, as last written
  logic [MOD_W-1:0] cur_modulus = MODULUS_RESET;

  int fail_count    = 0;
  int items_sent    = 0;
  int wide_items    = 0;
  int results_seen  = 0;
  int modulus_writes = 0;
  int idle_cycles   = 0;

  fibonacci_mod_matrix_power_unit u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_exponent   (in_exponent),
    .out_strobe    (out_strobe),
    .out_fib_value (out_fib_value),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // x * y with each product reduced before the sum is reduced
  function automatic mat2_t mat_mul_mod(mat2_t x, mat2_t y, logic [63:0] m);
    mat2_t r;
    r.a = ((x.a * y.a) % m + (x.b * y.c) % m) % m;
    r.b = ((x.a * y.b) % m + (x.b * y.d) % m) % m;
    r.c = ((x.c * y.a) % m + (x.d * y.c) % m) % m;
    r.d = ((x.c * y.b) % m + (x.d * y.d) % m) % m;
    return r;
  endfunction

  // lower-right entry of [[0,1],[1,1]]^n mod modulus, i.e. F(n+1)
  function automatic logic [MOD_W-1:0] predict_fib(logic [IN_W-1:0] n,
                                                   logic [MOD_W-1:0] modulus);
    logic [63:0] m;
    mat2_t       sq;
    mat2_t       acc;
    int          i;
    m = 64'(modulus);
    if (m == 0) return '0;
    // running square starts at the fibonacci matrix, product at identity
    sq.a = '0;
    sq.b = 1 % m;
    sq.c = 1 % m;
    sq.d = 1 % m;
    acc.a = 1 % m;
    acc.b = '0;
    acc.c = '0;
    acc.d = 1 % m;
    for (i = 0; i < IN_W; i++) begin
      if (n[i]) acc = mat_mul_mod(sq, acc, m);
      sq = mat_mul_mod(sq, sq, m);
    end
    return acc.d[MOD_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // sender gap: mostly none or short, now and then long
  function automatic int idle_gap(bit steady);
    int roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 20);
    return $urandom_range(50, 200);
  endfunction

  // exponent width is skewed small, since cost grows with the bit count;
  // a few items take the full 32 bits so the top bits toggle too
  function automatic logic [IN_W-1:0] rand_exponent();
    int roll;
    int width;
    roll = $urandom_range(0, 99);
    if (roll < 70)      width = $urandom_range(0, 4);
    else if (roll < 94) width = $urandom_range(5, 8);
    else if (roll < 99) width = $urandom_range(9, 16);
    else                return IN_W'($urandom());
    if (width == 0) return '0;
    return IN_W'($urandom()) & ((IN_W'(1) << width) - 1);
  endfunction

  // modulus for each random phase, extremes among them
  function automatic logic [MOD_W-1:0] phase_modulus(int ph);
    case (ph)
      0:       return MOD_W'($urandom());
      1:       return MOD_W'($urandom_range(2, 40));
      2:       return MOD_MAX;
      3:       return '0;
      4:       return MOD_W'($urandom()) | (MOD_W'(1) << (MOD_W - 1));
      5:       return MOD_W'(2);
      6:       return MOD_W'(1);
      default: return MOD_W'($urandom_range(3, 1000));
    endcase
  endfunction

  task automatic note_failure(string what, logic [MOD_W-1:0] expected_fib,
                              logic [MOD_W-1:0] actual_fib);
    fail_count++;
    if (fail_count <= REPORT_MAX)
      $display("[%0t] %s: fib_value expected %0d got %0d", $realtime, what,
               expected_fib, actual_fib);
  endtask

  // one exponent transfer; start is left high so a back-to-back item does
  // not lower and raise it in the same step
  task automatic send_exponent(logic [IN_W-1:0] exponent,
                               logic [MOD_W-1:0] fib, int gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    in_exponent <= exponent;
    do @(posedge clk); while (!(start && !busy));
    fib_expected_q = {fib_expected_q, fib};
    items_sent++;
    if (exponent[IN_W-1:16] != 0) wide_items++;
  endtask

  // hold the sender off until every owed result has come back
  task automatic drain_results();
    start <= 1'b0;
    while (fib_expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_modulus(logic [MOD_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid   <= 1'b0;
    cur_modulus = value;
    modulus_writes++;
  endtask

  // ---------------------------------------------------------------------------
  // result checker: a strobed result is taken at the edge that ends its cycle
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      results_seen++;
      if (fib_expected_q.size() == 0) begin
        note_failure("result with nothing outstanding", '0, out_fib_value);
      end else begin
        if (out_fib_value !== fib_expected_q[0])
          note_failure("mismatch", fib_expected_q[0], out_fib_value);
        void'(fib_expected_q.pop_front());
      end
    end
  end

  // watchdog: any transfer on any channel counts as progress
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("[%0t] no transfer for %0d cycles", $realtime, STALL_LIMIT);
      $display("fibonacci_mod_matrix_power_unit_test: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int  ph;
    int  k;
    int  count;
    bit  steady;
    logic [IN_W-1:0]  exponent;
    logic [MOD_W-1:0] fib;

    repeat (RESET_TICKS) @(posedge clk);
    rst_n <= 1'b1;

    // directed table; the first rows run on the reset modulus unwritten
    foreach (DIR_TABLE[r]) begin
      if (DIR_TABLE[r].modulus != cur_modulus) begin
        drain_results();
        write_modulus(DIR_TABLE[r].modulus);
      end
      fib = DIR_TABLE[r].known ? DIR_TABLE[r].fib
                               : predict_fib(DIR_TABLE[r].exponent, cur_modulus);
      send_exponent(DIR_TABLE[r].exponent, fib, idle_gap(1'b0));
    end

    // random phases, each on a modulus of its own; some run with no gaps
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      drain_results();
      write_modulus(phase_modulus(ph));
      steady = (ph % 3 == 1);
      // moduli 0 and 1 only ever give zero, so keep those phases short
      count = (cur_modulus < 2) ? 15 : 220;
      for (k = 0; k < count; k++) begin
        // occasional full stop until the unit has caught up
        if ($urandom_range(0, 99) < 3) drain_results();
        exponent = rand_exponent();
        send_exponent(exponent, predict_fib(exponent, cur_modulus),
                      idle_gap(steady));
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fib_expected_q.size() != 0) begin
      fail_count += fib_expected_q.size();
      $display("%0d results never arrived", fib_expected_q.size());
    end
    $display("checked %0d results for %0d exponents, %0d of them above 16 bits",
             results_seen, items_sent, wide_items);
    $display("modulus written %0d times, zero, one, two and the maximum included",
             modulus_writes);
    if (fail_count == 0) begin
      $display("fibonacci_mod_matrix_power_unit_test: PASS");
    end else begin
      $display("%0d failures", fail_count);
      $display("fibonacci_mod_matrix_power_unit_test: FAIL");
    end
    $finish;
  end

endmodule

### files.f
sv/fmmp_pkg.sv
sv/fibonacci_mod_matrix_power_unit.sv
tb/fibonacci_mod_matrix_power_unit_test.sv
